### rtl/qpc_pkg.sv
// Shared types and constants of the quadrature pulse counter.
// Holds the mode and operation codes and the input and result transaction
// structs. It depends on nothing else.
`default_nettype none

package qpc_pkg;

    // Widths that the transaction fields fix.
    localparam int CHAN_W     = 2;
    localparam int POS_W      = 32;
    localparam int MODE_W     = 2;
    localparam int MODE_REGS  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MODE_W;

    // Channel modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_STOP  = 2'd0,
        MODE_HALF  = 2'd1,
        MODE_FULL  = 2'd2,
        MODE_PULSE = 2'd3
    } t_mode;

    // Input operation codes.
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // One input transaction.
    typedef struct packed {
        logic              operation;
        logic [CHAN_W-1:0] channel;
        logic              level_a;
        logic              level_b;
    } t_qpc_in;

    // One result transaction.
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    moved;
    } t_qpc_out;

endpackage

`default_nettype wire

### rtl/quadrature_pulse_counter.sv
// Top level of the quadrature pulse counter: per-channel edge decoding,
// counters and the result register. Depends on qpc_pkg.
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------
// input     | in        | i_in_valid / o_in_ready    | i_in_data
// result    | out       | o_out_valid / i_out_ready  | o_out_data
// config    | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// Each transaction is decoded and applied to its channel's counter in the
// cycle it is accepted and its result is registered, so one transaction per
// cycle is sustained unless the output stalls. The limit is the single
// compare-and-increment path from the channel state into the result register.
// The input is held off only while a result waits in the output register.
// Synchronous reset clears all counts, stored levels and modes (stopped).

module quadrature_pulse_counter #(
    parameter int CHANNELS   = 4,
    parameter int COUNT_BITS = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire qpc_pkg::t_qpc_in       i_in_data,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output qpc_pkg::t_qpc_out           o_out_data,
    input  wire                         i_cfg_we,
    input  wire [qpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [qpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import qpc_pkg::*;

    logic                  w_accept;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_qpc_out              r_out_data;
    t_qpc_out              n_out_data;
    t_mode                 r_mode [MODE_REGS];
    logic [POS_W-1:0]      w_pos  [CHANNELS];
    logic                  w_mv   [CHANNELS];

    // Output register frees the input side whenever it is empty or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Mode registers, written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MODE_REGS; m++) begin
                r_mode[m] <= MODE_STOP;
            end
        end else if (i_cfg_we) begin
            r_mode[i_cfg_index] <= t_mode'(i_cfg_data);
        end
    end

    // Per-channel decoder and counter.
    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        logic                  hit;
        logic                  restart;
        t_mode                 mode;
        logic [COUNT_BITS-1:0] r_cnt;
        logic [COUNT_BITS-1:0] n_cnt;
        logic                  r_la;
        logic                  n_la;
        logic                  r_lb;
        logic                  n_lb;
        logic                  mv;
        logic [63:0]           cnt_ext;

        // Only channels that have a mode register can be addressed.
        if (c < MODE_REGS) begin : g_live
            assign hit     = w_accept
                             && ({2'b00, i_in_data.channel} == 4'(c));
            assign restart = i_cfg_we
                             && ({2'b00, i_cfg_index} == 4'(c));
            assign mode    = r_mode[c];
        end else begin : g_dead
            assign hit     = 1'b0;
            assign restart = 1'b0;
            assign mode    = MODE_STOP;
        end

        // Edge detection against the stored levels, then the count update.
        always_comb begin
            n_cnt = r_cnt;
            n_la  = r_la;
            n_lb  = r_lb;
            mv    = 1'b0;
            if (hit) begin
                if (i_in_data.operation == OP_CLEAR) begin
                    n_cnt = '0;
                    n_la  = 1'b0;
                    n_lb  = 1'b0;
                end else begin
                    unique case (mode)
                        MODE_STOP: begin
                        end
                        MODE_HALF: begin
                            if (i_in_data.level_a != r_la) begin
                                mv    = 1'b1;
                                n_cnt = (i_in_data.level_a == i_in_data.level_b)
                                        ? r_cnt - COUNT_BITS'(1)
                                        : r_cnt + COUNT_BITS'(1);
                            end
                            n_la = i_in_data.level_a;
                            n_lb = i_in_data.level_b;
                        end
                        MODE_FULL: begin
                            if (i_in_data.level_a != r_la) begin
                                mv    = 1'b1;
                                n_cnt = (i_in_data.level_a == i_in_data.level_b)
                                        ? r_cnt - COUNT_BITS'(1)
                                        : r_cnt + COUNT_BITS'(1);
                                n_la  = i_in_data.level_a;
                            end else if (i_in_data.level_b != r_lb) begin
                                mv    = 1'b1;
                                n_cnt = (i_in_data.level_a == i_in_data.level_b)
                                        ? r_cnt + COUNT_BITS'(1)
                                        : r_cnt - COUNT_BITS'(1);
                                n_lb  = i_in_data.level_b;
                            end
                        end
                        MODE_PULSE: begin
                            if (i_in_data.level_a && !r_la) begin
                                mv    = 1'b1;
                                n_cnt = r_cnt + COUNT_BITS'(1);
                            end
                            n_la = i_in_data.level_a;
                            n_lb = i_in_data.level_b;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // A mode write restarts the channel.
            if (restart) begin
                n_cnt = '0;
                n_la  = 1'b0;
                n_lb  = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt <= '0;
                r_la  <= 1'b0;
                r_lb  <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_la  <= n_la;
                r_lb  <= n_lb;
            end
        end

        // Result contribution: zero unless this channel is addressed.
        assign cnt_ext  = 64'(n_cnt);
        assign w_pos[c] = hit ? cnt_ext[POS_W-1:0] : '0;
        assign w_mv[c]  = hit && mv;
    end

    // Collect the addressed channel's result; an unknown channel gives zero.
    always_comb begin
        n_out_data = r_out_data;
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_data.position = '0;
            n_out_data.moved    = 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                n_out_data.position = n_out_data.position | w_pos[c];
                n_out_data.moved    = n_out_data.moved | w_mv[c];
            end
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### rtl/qpc_checker.sv
// Port-level checks for the quadrature pulse counter, bound to the top level.
// Depends on qpc_pkg and the port names of quadrature_pulse_counter.
`default_nettype none

module qpc_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_in_valid,
    input wire                    o_in_ready,
    input wire qpc_pkg::t_qpc_in  i_in_data,
    input wire                    o_out_valid,
    input wire                    i_out_ready,
    input wire qpc_pkg::t_qpc_out o_out_data
);
    import qpc_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Every accepted input transaction yields a result in the next cycle.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // A stalled result blocks further input.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result stalled");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // A clear answers a zero count and no movement.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.operation == OP_CLEAR)
        |=> (o_out_data.position == '0 && !o_out_data.moved))
        else $error("clear did not report a zero count");

endmodule

bind quadrature_pulse_counter qpc_checker u_qpc_checker (.*);

`default_nettype wire

### sim/tb.sv
// Testbench of the quadrature pulse counter: directed edge cases, then random
// phases of encoder motion checked against an in-bench predictor.
// Depends on qpc_pkg and quadrature_pulse_counter from the rtl folder.
`timescale 1ns / 100ps

module tb;

    import qpc_pkg::*;

    localparam int NUM_CH          = 4;
    localparam int STALL_PCT       = 6;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 140;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_qpc_in               in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_qpc_out              out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: one counter, stored levels and mode per channel.
    logic [POS_W-1:0] chan_count [NUM_CH];
    logic             prev_a     [NUM_CH];
    logic             prev_b     [NUM_CH];
    t_mode            chan_mode  [NUM_CH];

    // Positions and moved flags still to come from the block, oldest first.
    t_qpc_out count_results_due [$];

    // Levels of the simulated encoder pins and its direction of travel.
    logic pin_a   [NUM_CH];
    logic pin_b   [NUM_CH];
    logic pin_dir [NUM_CH];

    logic idle_en = 1'b1;
    int   fail_count = 0;
    int   quiet_cycles = 0;

    quadrature_pulse_counter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // The result side stalls now and then, changing at the falling edge.
    always @(negedge clk) begin
        out_ready = idle_en ? ($urandom_range(99) >= STALL_PCT) : 1'b1;
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Compare each result transaction with the oldest predicted one.
    always @(posedge clk) begin
        t_qpc_out want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (count_results_due.size() == 0) begin
                $error("result with no pending transaction: position %0d, moved %0d",
                       out_data.position, out_data.moved);
                fail_count++;
            end else begin
                want = count_results_due.pop_front();
                if (out_data.position !== want.position) begin
                    $error("position mismatch: expected %0d, actual %0d",
                           want.position, out_data.position);
                    fail_count++;
                end
                if (out_data.moved !== want.moved) begin
                    $error("moved mismatch: expected %0d, actual %0d",
                           want.moved, out_data.moved);
                    fail_count++;
                end
            end
        end
    end

    // Zero the count and stored levels of one channel.
    function automatic void restart_channel(int ch);
        chan_count[ch] = '0;
        prev_a[ch]     = 1'b0;
        prev_b[ch]     = 1'b0;
    endfunction

    // Decode one transaction against the channel state and return its result.
    function automatic t_qpc_out decode_edges(t_qpc_in it);
        t_qpc_out         res;
        logic [POS_W-1:0] step;
        logic             mv;
        int               ch;
        ch   = it.channel;
        step = '0;
        mv   = 1'b0;
        if (it.operation == OP_CLEAR) begin
            restart_channel(ch);
        end else begin
            case (chan_mode[ch])
                MODE_HALF: begin
                    if (it.level_a != prev_a[ch]) begin
                        step = (it.level_a == it.level_b) ? '1 : POS_W'(1);
                        mv   = 1'b1;
                    end
                    prev_a[ch] = it.level_a;
                    prev_b[ch] = it.level_b;
                end
                MODE_FULL: begin
                    // A change wins; a B change in the same sample waits a sample.
                    if (it.level_a != prev_a[ch]) begin
                        step = (it.level_a == it.level_b) ? '1 : POS_W'(1);
                        mv   = 1'b1;
                        prev_a[ch] = it.level_a;
                    end else if (it.level_b != prev_b[ch]) begin
                        step = (it.level_a == it.level_b) ? POS_W'(1) : '1;
                        mv   = 1'b1;
                        prev_b[ch] = it.level_b;
                    end
                end
                MODE_PULSE: begin
                    if (it.level_a && !prev_a[ch]) begin
                        step = POS_W'(1);
                        mv   = 1'b1;
                    end
                    prev_a[ch] = it.level_a;
                    prev_b[ch] = it.level_b;
                end
                default: begin
                end
            endcase
            if (mv) begin
                chan_count[ch] = chan_count[ch] + step;
            end
        end
        res.position = chan_count[ch];
        res.moved    = mv;
        return res;
    endfunction

    // Offer one input transaction, starting and ending at a falling edge.
    task automatic apply_encoder_item(t_qpc_in it);
        while (idle_en && $urandom_range(99) < STALL_PCT) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        forever begin
            @(posedge clk);
            if (in_ready === 1'b1) break;
        end
        count_results_due.push_back(decode_edges(it));
        @(negedge clk);
    endtask

    task automatic send_sample(int ch, logic a, logic b);
        t_qpc_in it;
        it.operation = OP_SAMPLE;
        it.channel   = CHAN_W'(ch);
        it.level_a   = a;
        it.level_b   = b;
        apply_encoder_item(it);
    endtask

    task automatic send_clear(int ch, logic a, logic b);
        t_qpc_in it;
        it.operation = OP_CLEAR;
        it.channel   = CHAN_W'(ch);
        it.level_a   = a;
        it.level_b   = b;
        apply_encoder_item(it);
    endtask

    // Hold the input off until every pending result has arrived.
    task automatic wait_results_drained();
        in_valid = 1'b0;
        while (count_results_due.size() != 0) @(negedge clk);
    endtask

    // Write the selected mode registers once the block is idle.
    task automatic program_modes(t_mode modes [NUM_CH], logic [NUM_CH-1:0] sel);
        wait_results_drained();
        for (int i = 0; i < NUM_CH; i++) begin
            if (sel[i]) begin
                cfg_we    = 1'b1;
                cfg_index = CFG_IDX_W'(i);
                cfg_data  = modes[i];
                @(posedge clk);
                chan_mode[i] = modes[i];
                restart_channel(i);
                @(negedge clk);
            end
        end
        cfg_we = 1'b0;
    endtask

    task automatic program_one_mode(int ch, t_mode mode);
        t_mode modes [NUM_CH];
        for (int i = 0; i < NUM_CH; i++) modes[i] = MODE_STOP;
        modes[ch] = mode;
        program_modes(modes, NUM_CH'(1) << ch);
    endtask

    // Channels left stopped after reset count no samples; a clear keeps them at zero.
    task automatic test_stopped_channels();
        send_sample(0, 1'b1, 1'b1);
        send_sample(3, 1'b1, 1'b0);
        send_clear(1, 1'b1, 1'b1);
    endtask

    // Half resolution counts only changes on A, forward then backward.
    task automatic test_half_quadrature();
        program_one_mode(0, MODE_HALF);
        send_sample(0, 1'b1, 1'b0);
        send_sample(0, 1'b1, 1'b1);
        send_sample(0, 1'b0, 1'b1);
        send_sample(0, 1'b0, 1'b0);
        send_sample(0, 1'b0, 1'b1);
        send_sample(0, 1'b1, 1'b1);
    endtask

    // Full resolution counts every edge; a double change is split over two samples.
    task automatic test_full_quadrature();
        program_one_mode(1, MODE_FULL);
        send_sample(1, 1'b1, 1'b0);
        send_sample(1, 1'b1, 1'b1);
        send_sample(1, 1'b0, 1'b1);
        send_sample(1, 1'b0, 1'b0);
        send_sample(1, 1'b0, 1'b1);
        send_sample(1, 1'b1, 1'b0);
        send_sample(1, 1'b1, 1'b0);
    endtask

    // Pulse mode counts rising edges of A only.
    task automatic test_pulse_counting();
        program_one_mode(2, MODE_PULSE);
        send_sample(2, 1'b1, 1'b0);
        send_sample(2, 1'b0, 1'b0);
        send_sample(2, 1'b1, 1'b1);
        send_sample(2, 1'b1, 1'b1);
    endtask

    // Counting down from zero wraps to all ones; a clear brings it back.
    task automatic test_clear_below_zero();
        program_one_mode(3, MODE_HALF);
        send_sample(3, 1'b0, 1'b1);
        send_sample(3, 1'b1, 1'b1);
        send_clear(3, 1'b1, 1'b1);
        send_sample(3, 1'b0, 1'b0);
        send_clear(0, 1'b0, 1'b0);
    endtask

    // Random phases of encoder motion, each under its own set of modes.
    task automatic test_random_phases();
        t_mode modes [NUM_CH];
        int    ch;
        int    roll;
        for (int i = 0; i < NUM_CH; i++) begin
            pin_a[i]   = 1'b0;
            pin_b[i]   = 1'b0;
            pin_dir[i] = 1'($urandom_range(1));
        end
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            for (int i = 0; i < NUM_CH; i++) begin
                if (ph == 0)      modes[i] = MODE_FULL;
                else if (ph == 1) modes[i] = t_mode'(i);
                else if (ph == 2) modes[i] = MODE_PULSE;
                else              modes[i] = t_mode'($urandom_range(3));
            end
            program_modes(modes, '1);
            // One phase runs with no stalls on either side.
            idle_en = (ph != 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                ch   = $urandom_range(NUM_CH - 1);
                roll = $urandom_range(99);
                if ($urandom_range(99) < 10) pin_dir[ch] = ~pin_dir[ch];
                if (roll < 78) begin
                    // One Gray-code step in the channel's direction of travel.
                    if ((pin_a[ch] == pin_b[ch]) ^ pin_dir[ch]) pin_a[ch] = ~pin_a[ch];
                    else                                        pin_b[ch] = ~pin_b[ch];
                    send_sample(ch, pin_a[ch], pin_b[ch]);
                end else if (roll < 84) begin
                    send_sample(ch, pin_a[ch], pin_b[ch]);
                end else if (roll < 94) begin
                    // Noise: any levels, double changes among them.
                    pin_a[ch] = 1'($urandom_range(1));
                    pin_b[ch] = 1'($urandom_range(1));
                    send_sample(ch, pin_a[ch], pin_b[ch]);
                end else begin
                    send_clear(ch, 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                // Once, in one phase, the sender waits for every result mid-phase.
                if (n == ITEMS_PER_PHASE / 2 && ph == 3) wait_results_drained();
            end
        end
        idle_en = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < NUM_CH; i++) begin
            chan_mode[i] = MODE_STOP;
            restart_channel(i);
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_stopped_channels();
        test_half_quadrature();
        test_full_quadrature();
        test_pulse_counting();
        test_clear_below_zero();
        test_random_phases();

        wait_results_drained();
        repeat (5) @(posedge clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### quadrature_pulse_counter.f
rtl/qpc_pkg.sv
rtl/quadrature_pulse_counter.sv
rtl/qpc_checker.sv
sim/tb.sv
